// File: hdl/fcc_pkg.sv
// Shared types and constants for the framed container checker.
// Holds the front-to-back work item, operation codes, status codes and the signature table.
// No dependencies.
`default_nettype none

package fcc_pkg;

    // Length field and trailing checksum are both four bytes wide.
    localparam int LEN_BYTES      = 4;
    localparam int CHECKSUM_BYTES = 4;
    localparam int SIG_LEN        = 9;

    // Adler-32 modulus.
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Final status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIG  = 3'd1;
    localparam logic [2:0] ST_HDR_SUM  = 3'd2;
    localparam logic [2:0] ST_BODY_SUM = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    // What the back end does with one byte.
    typedef enum logic [2:0] {
        OP_NONE,        // byte is ignored
        OP_ADD,         // byte goes into the running checksum
        OP_STORE,       // byte is part of a stored checksum
        OP_SIZE,        // checksum byte that also holds a block-size byte
        OP_PAYLOAD,     // checksum byte that is forwarded as payload
        OP_HDR_CHECK,   // last stored header checksum byte, compare
        OP_BODY_CHECK,  // last stored body checksum byte, compare
        OP_FAIL         // parse error found by the front end
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [2:0] code;      // fail code: OP_FAIL, OP_HDR_CHECK; pass code: OP_BODY_CHECK
        logic [1:0] lane;      // byte lane of the block-size field for OP_SIZE
        logic       eof;
        logic [2:0] eof_code;  // status when no error has been held before end of file
    } item_t;

    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h98;
            4'd1:    val = 8'h57;
            4'd2:    val = 8'h42;
            4'd3:    val = 8'h43;
            4'd4:    val = 8'h31;
            4'd5:    val = 8'h0D;
            4'd6:    val = 8'h0A;
            4'd7:    val = 8'h1A;
            4'd8:    val = 8'h0A;
            default: val = 8'h98;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: hdl/fcc_queue.sv
// Short FIFO of classified work items between the front and back ends.
// Depends on fcc_pkg for the item type and depth.
`default_nettype none

module fcc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    input  wire fcc_pkg::item_t wr_item,
    output logic               wr_ready,
    output logic               rd_valid,
    output fcc_pkg::item_t     rd_item,
    input  wire logic          rd_ready
);

    localparam int DEPTH = fcc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fcc_pkg::item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/fcc_front.sv
// Front end: tracks the file layout (signature, header, body, block-size field) and turns
// each accepted byte into one work item for the back end. Depends on fcc_pkg.
`default_nettype none

module fcc_front #(
    parameter int TYPE_TAG_BYTES   = 4,
    parameter int LZ4_PREFIX_BYTES = 7
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic [7:0] data_byte,
    input  wire logic      end_of_file,
    input  wire logic      accept,
    output fcc_pkg::item_t item
);

    localparam logic [31:0] SIZE_START =
        32'(fcc_pkg::LEN_BYTES + TYPE_TAG_BYTES + LZ4_PREFIX_BYTES);
    localparam logic [31:0] SIZE_END   = SIZE_START + 32'd4;
    localparam logic [31:0] LEN_BYTES  = 32'(fcc_pkg::LEN_BYTES);
    localparam logic [31:0] LEN_LAST   = 32'(fcc_pkg::LEN_BYTES - 1);
    localparam logic [31:0] CSUM_BYTES = 32'(fcc_pkg::CHECKSUM_BYTES);
    localparam logic [31:0] MIN_LEN    = 32'(fcc_pkg::LEN_BYTES + fcc_pkg::CHECKSUM_BYTES);
    localparam logic [31:0] SIG_LAST   = 32'(fcc_pkg::SIG_LEN - 1);

    typedef enum logic [1:0] {PH_SIG, PH_HEAD, PH_BODY, PH_TAIL} phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] hlen_reg, hlen_next;
    logic [31:0] blen_reg, blen_next;
    logic [31:0] blk_reg, blk_next;
    logic [31:0] remain_reg, remain_next;
    logic        overrun_reg, overrun_next;

    logic [31:0] pos_inc;
    logic [31:0] hlen_shift;
    logic [31:0] blen_shift;
    logic [31:0] content;
    logic [31:0] size_off;

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        hlen_next    = hlen_reg;
        blen_next    = blen_reg;
        blk_next     = blk_reg;
        remain_next  = remain_reg;
        overrun_next = overrun_reg;

        pos_inc    = pos_reg + 32'd1;
        hlen_shift = {hlen_reg[23:0], data_byte};
        blen_shift = {blen_reg[23:0], data_byte};
        content    = blen_reg - CSUM_BYTES;
        size_off   = pos_reg - SIZE_START;

        item.op       = fcc_pkg::OP_NONE;
        item.data     = data_byte;
        item.code     = fcc_pkg::ST_OK;
        item.lane     = size_off[1:0];
        item.eof      = end_of_file;
        item.eof_code = fcc_pkg::ST_OK;

        case (phase_reg)
            PH_SIG: begin
                if (data_byte != fcc_pkg::sig_byte(pos_reg[3:0])) begin
                    item.op    = fcc_pkg::OP_FAIL;
                    item.code  = fcc_pkg::ST_BAD_SIG;
                    phase_next = PH_TAIL;
                end else if (pos_reg == SIG_LAST) begin
                    phase_next = PH_HEAD;
                    pos_next   = '0;
                end else begin
                    pos_next = pos_inc;
                end
            end
            PH_HEAD: begin
                if (pos_reg < LEN_BYTES) begin
                    item.op   = fcc_pkg::OP_ADD;
                    hlen_next = hlen_shift;
                end else if (pos_reg < hlen_reg - CSUM_BYTES) begin
                    item.op = fcc_pkg::OP_ADD;
                end else begin
                    item.op = fcc_pkg::OP_STORE;
                end
                pos_next = pos_inc;
                if (pos_reg == LEN_LAST && hlen_shift < MIN_LEN) begin
                    item.op    = fcc_pkg::OP_FAIL;
                    item.code  = fcc_pkg::ST_HDR_SUM;
                    phase_next = PH_TAIL;
                end else if (pos_reg > LEN_LAST && pos_inc == hlen_reg) begin
                    // The back end decides whether the header passed; the body is
                    // classified regardless and dropped there on a mismatch.
                    item.op    = fcc_pkg::OP_HDR_CHECK;
                    item.code  = fcc_pkg::ST_HDR_SUM;
                    phase_next = PH_BODY;
                    pos_next   = '0;
                end
            end
            PH_BODY: begin
                if (pos_reg < LEN_BYTES) begin
                    item.op   = fcc_pkg::OP_ADD;
                    blen_next = blen_shift;
                end else if (pos_reg < content) begin
                    if (pos_reg >= SIZE_START && pos_reg < SIZE_END) begin
                        item.op = fcc_pkg::OP_SIZE;
                        for (int i = 0; i < 4; i++) begin
                            if (size_off[1:0] == 2'(i)) begin
                                blk_next[8*i +: 8] = blk_reg[8*i +: 8] | data_byte;
                            end
                        end
                        if (pos_reg == SIZE_END - 32'd1) begin
                            remain_next = blk_next;
                            if ({1'b0, SIZE_END} + {1'b0, blk_next} > {1'b0, content}) begin
                                overrun_next = 1'b1;
                            end
                        end
                    end else if (pos_reg >= SIZE_END && remain_reg != '0) begin
                        item.op     = fcc_pkg::OP_PAYLOAD;
                        remain_next = remain_reg - 32'd1;
                    end else begin
                        item.op = fcc_pkg::OP_ADD;
                    end
                end else begin
                    item.op = fcc_pkg::OP_STORE;
                end
                pos_next = pos_inc;
                if (pos_reg == LEN_LAST) begin
                    if (blen_shift < MIN_LEN) begin
                        item.op    = fcc_pkg::OP_FAIL;
                        item.code  = fcc_pkg::ST_BODY_SUM;
                        phase_next = PH_TAIL;
                    end else if (blen_shift - CSUM_BYTES < SIZE_END) begin
                        overrun_next = 1'b1;
                    end
                end else if (pos_reg > LEN_LAST && pos_inc == blen_reg) begin
                    item.op    = fcc_pkg::OP_BODY_CHECK;
                    item.code  = overrun_reg ? fcc_pkg::ST_TRUNC : fcc_pkg::ST_OK;
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL: begin
                item.op = fcc_pkg::OP_NONE;
            end
            default: begin
                phase_next = PH_TAIL;
            end
        endcase

        // Status to report at end of file if the back end holds no earlier outcome.
        case (phase_next)
            PH_SIG:  item.eof_code = fcc_pkg::ST_BAD_SIG;
            PH_TAIL: item.eof_code = fcc_pkg::ST_OK;
            default: item.eof_code = fcc_pkg::ST_TRUNC;
        endcase

        if (end_of_file) begin
            phase_next   = PH_SIG;
            pos_next     = '0;
            hlen_next    = '0;
            blen_next    = '0;
            blk_next     = '0;
            remain_next  = '0;
            overrun_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIG;
            pos_reg     <= '0;
            hlen_reg    <= '0;
            blen_reg    <= '0;
            blk_reg     <= '0;
            remain_reg  <= '0;
            overrun_reg <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            hlen_reg    <= hlen_next;
            blen_reg    <= blen_next;
            blk_reg     <= blk_next;
            remain_reg  <= remain_next;
            overrun_reg <= overrun_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/fcc_back.sv
// Back end: runs the Adler-32 accumulator, checks stored sums, holds the first error and
// drives the registered result channel. Depends on fcc_pkg.
`default_nettype none

module fcc_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire fcc_pkg::item_t q_item,
    output logic                q_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_result_kind,
    output logic [7:0]          m_payload_byte,
    output logic [2:0]          m_status,
    output logic [31:0]         m_block_size,
    output logic                m_final_flag
);

    logic        held_valid_reg, held_valid_next;
    logic [2:0]  held_code_reg, held_code_next;
    logic [15:0] sum_lo_reg, sum_lo_next;
    logic [15:0] sum_hi_reg, sum_hi_next;
    logic [31:0] stored_reg, stored_next;
    logic [31:0] blk_reg, blk_next;

    logic        m_valid_reg, m_valid_next;
    logic        m_kind_reg, m_kind_next;
    logic [7:0]  m_payload_reg, m_payload_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic [31:0] m_block_reg, m_block_next;
    logic        m_final_reg, m_final_next;

    logic        pop;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_new, hi_new;
    logic [31:0] stored_shift;
    logic [31:0] adler;

    assign q_ready = !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_payload_byte = m_payload_reg;
    assign m_status       = m_status_reg;
    assign m_block_size   = m_block_reg;
    assign m_final_flag   = m_final_reg;

    // One Adler-32 update: two adds, each reduced by at most one modulus.
    always_comb begin
        lo_sum = {1'b0, sum_lo_reg} + {9'b0, q_item.data};
        lo_new = (lo_sum >= fcc_pkg::ADLER_MOD) ? 16'(lo_sum - fcc_pkg::ADLER_MOD)
                                                : lo_sum[15:0];
        hi_sum = {1'b0, sum_hi_reg} + {1'b0, lo_new};
        hi_new = (hi_sum >= fcc_pkg::ADLER_MOD) ? 16'(hi_sum - fcc_pkg::ADLER_MOD)
                                                : hi_sum[15:0];
    end

    assign stored_shift = {stored_reg[23:0], q_item.data};
    assign adler        = {sum_hi_reg, sum_lo_reg};

    always_comb begin
        held_valid_next = held_valid_reg;
        held_code_next  = held_code_reg;
        sum_lo_next     = sum_lo_reg;
        sum_hi_next     = sum_hi_reg;
        stored_next     = stored_reg;
        blk_next        = blk_reg;

        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_payload_next = m_payload_reg;
        m_status_next  = m_status_reg;
        m_block_next   = m_block_reg;
        m_final_next   = m_final_reg;

        if (pop) begin
            if (!held_valid_reg) begin
                case (q_item.op)
                    fcc_pkg::OP_ADD, fcc_pkg::OP_PAYLOAD: begin
                        sum_lo_next = lo_new;
                        sum_hi_next = hi_new;
                    end
                    fcc_pkg::OP_SIZE: begin
                        sum_lo_next = lo_new;
                        sum_hi_next = hi_new;
                        for (int i = 0; i < 4; i++) begin
                            if (q_item.lane == 2'(i)) begin
                                blk_next[8*i +: 8] = blk_reg[8*i +: 8] | q_item.data;
                            end
                        end
                    end
                    fcc_pkg::OP_STORE: begin
                        stored_next = stored_shift;
                    end
                    fcc_pkg::OP_HDR_CHECK: begin
                        if (stored_shift != adler) begin
                            held_valid_next = 1'b1;
                            held_code_next  = q_item.code;
                        end else begin
                            sum_lo_next = 16'd1;
                            sum_hi_next = '0;
                            stored_next = '0;
                        end
                    end
                    fcc_pkg::OP_BODY_CHECK: begin
                        held_valid_next = 1'b1;
                        held_code_next  = (stored_shift != adler) ? fcc_pkg::ST_BODY_SUM
                                                                  : q_item.code;
                    end
                    fcc_pkg::OP_FAIL: begin
                        held_valid_next = 1'b1;
                        held_code_next  = q_item.code;
                    end
                    default: begin
                    end
                endcase
            end

            if (q_item.eof) begin
                m_valid_next   = 1'b1;
                m_kind_next    = 1'b1;
                m_payload_next = '0;
                m_status_next  = held_valid_next ? held_code_next : q_item.eof_code;
                m_block_next   = blk_next;
                m_final_next   = 1'b1;
                held_valid_next = 1'b0;
                held_code_next  = fcc_pkg::ST_OK;
                sum_lo_next     = 16'd1;
                sum_hi_next     = '0;
                stored_next     = '0;
                blk_next        = '0;
            end else if (!held_valid_reg && q_item.op == fcc_pkg::OP_PAYLOAD) begin
                m_valid_next   = 1'b1;
                m_kind_next    = 1'b0;
                m_payload_next = q_item.data;
                m_status_next  = fcc_pkg::ST_OK;
                m_block_next   = blk_reg;
                m_final_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_code_reg  <= fcc_pkg::ST_OK;
            sum_lo_reg     <= 16'd1;
            sum_hi_reg     <= '0;
            stored_reg     <= '0;
            blk_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_code_reg  <= held_code_next;
            sum_lo_reg     <= sum_lo_next;
            sum_hi_reg     <= sum_hi_next;
            stored_reg     <= stored_next;
            blk_reg        <= blk_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg    <= m_kind_next;
        m_payload_reg <= m_payload_next;
        m_status_reg  <= m_status_next;
        m_block_reg   <= m_block_next;
        m_final_reg   <= m_final_next;
    end

endmodule

`default_nettype wire

// File: hdl/framed_container_checker.sv
// Top level of the framed container checker: front end, work queue and back end.
// Depends on fcc_pkg, fcc_front, fcc_queue and fcc_back.
//
// The block takes a container file one byte per transfer on the s_ channel, with
// s_end_of_file marking the last byte, and sustains one byte per clock cycle as long as
// the result side keeps m_ready high. It checks the nine-byte signature, parses the
// big-endian header and body lengths, verifies the Adler-32 of each against the stored
// big-endian value, and forwards the data-block bytes (whose size is a little-endian
// field inside the body) as payload transfers while they arrive. Exactly one status
// transfer with m_final_flag set follows each file, carried on its last byte; a status
// other than zero means the forwarded payload must be discarded. The front end
// classifies each byte in the cycle it is accepted and writes it into a two-entry queue;
// the back end pops one item per cycle, updates the Adler-32 accumulator (the add and
// reduce chain that sets the clock period) and loads the output register, so each
// payload or status transfer passes through a queue entry and the output register
// before it is presented on the m_ channel. While a result waits on m_ready the back
// end pops nothing, so the queue takes at most two more bytes and then s_ready stays
// low until the result is taken. After the status transfer the block is back in its
// reset state and the next file can start on the following byte.
`default_nettype none

module framed_container_checker #(
    parameter int TYPE_TAG_BYTES   = 4,
    parameter int LZ4_PREFIX_BYTES = 7
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_file,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [7:0]       m_payload_byte,
    output logic [2:0]       m_status,
    output logic [31:0]      m_block_size,
    output logic             m_final_flag
);

    fcc_pkg::item_t front_item;
    fcc_pkg::item_t queue_item;
    logic           s_accept;
    logic           queue_valid;
    logic           queue_ready;

    // A byte is classified in the cycle its transfer completes.
    assign s_accept = s_valid && s_ready;

    fcc_front #(
        .TYPE_TAG_BYTES  (TYPE_TAG_BYTES),
        .LZ4_PREFIX_BYTES(LZ4_PREFIX_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .data_byte  (s_data_byte),
        .end_of_file(s_end_of_file),
        .accept     (s_accept),
        .item       (front_item)
    );

    // The queue's free space is the input ready, so the front end never stalls on its own.
    fcc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(s_valid),
        .wr_item (front_item),
        .wr_ready(s_ready),
        .rd_valid(queue_valid),
        .rd_item (queue_item),
        .rd_ready(queue_ready)
    );

    fcc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (queue_valid),
        .q_item        (queue_item),
        .q_ready       (queue_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_payload_byte(m_payload_byte),
        .m_status      (m_status),
        .m_block_size  (m_block_size),
        .m_final_flag  (m_final_flag)
    );

endmodule

`default_nettype wire

// File: hdl/fcc_checker.sv
// Port-level checks for the framed container checker, bound to its top level.
// Depends on fcc_pkg for the status codes.
`default_nettype none

module fcc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_result_kind,
    input wire logic [7:0]  m_payload_byte,
    input wire logic [2:0]  m_status,
    input wire logic [31:0] m_block_size,
    input wire logic        m_final_flag
);

    // A result that is not taken stays on the port unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) && $stable(m_payload_byte)
            && $stable(m_status) && $stable(m_block_size) && $stable(m_final_flag))
        else $error("result changed while stalled");

    // Only a status transfer ends a file, and a status transfer always does.
    a_final_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_final_flag == m_result_kind)
        else $error("final flag disagrees with result kind");

    // Payload transfers carry no status and only occur once a nonzero block size is known.
    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_kind |-> m_status == fcc_pkg::ST_OK && m_block_size != 32'd0)
        else $error("payload transfer with status or zero block size");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == fcc_pkg::ST_OK || m_status == fcc_pkg::ST_BAD_SIG
            || m_status == fcc_pkg::ST_HDR_SUM || m_status == fcc_pkg::ST_BODY_SUM
            || m_status == fcc_pkg::ST_TRUNC)
        else $error("status code out of range");

endmodule

bind framed_container_checker fcc_checker u_fcc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_payload_byte(m_payload_byte),
    .m_status      (m_status),
    .m_block_size  (m_block_size),
    .m_final_flag  (m_final_flag)
);

`default_nettype wire
